// ===== rtl/core/lfu_pkg.sv =====
// Shared types and constants for the LFU cache table.
// Used by the slot scanner and the top level; no dependencies of its own.
package lfu_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W   = $clog2(ENTRIES + 1);
    localparam int CAP_W   = 5;
    localparam int CMP_W   = (CAP_W > OCC_W) ? CAP_W : OCC_W;
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int CNT_W   = 32;
    localparam int TOUCH_W = 64;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef enum logic {
        FUNC_GET = 1'b0,
        FUNC_PUT = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VAL_W-1:0]   value;
        logic [CNT_W-1:0]   use_count;
        logic [TOUCH_W-1:0] last_touch;
    } slot_entry_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

    // One entry as it comes back from the slot memory during a scan.
    typedef struct packed {
        logic             vld;
        logic [IDX_W-1:0] idx;
        logic             slot_valid;
        slot_entry_t      entry;
    } scan_beat_t;

    typedef struct packed {
        logic             match_found;
        logic [IDX_W-1:0] match_idx;
        slot_entry_t      match_entry;
        logic             victim_found;
        logic [IDX_W-1:0] victim_idx;
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
    } scan_result_t;

endpackage

// ===== rtl/core/lfu_slot_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No package dependency.
module lfu_slot_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/lfu_scan.sv =====
// Slot scanner: consumes one memory entry per cycle, finds the key match,
// the eviction victim and the lowest free slot. Depends on lfu_pkg.
module lfu_scan (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      clear,
    input  logic [lfu_pkg::KEY_W-1:0] key,
    input  lfu_pkg::scan_beat_t       beat,
    output lfu_pkg::scan_result_t     result
);
    import lfu_pkg::*;

    logic               match_found_reg;
    logic [IDX_W-1:0]   match_idx_reg;
    slot_entry_t        match_entry_reg;
    logic               victim_found_reg;
    logic [IDX_W-1:0]   victim_idx_reg;
    logic [CNT_W-1:0]   victim_cnt_reg;
    logic [TOUCH_W-1:0] victim_touch_reg;
    logic               free_found_reg;
    logic [IDX_W-1:0]   free_idx_reg;

    logic is_match;
    logic is_better;
    logic is_free;

    always_comb begin
        is_match  = beat.vld && beat.slot_valid && (beat.entry.key == key);
        is_free   = beat.vld && !beat.slot_valid && !free_found_reg;
        // Smallest use count wins; equal counts go to the oldest touch.
        is_better = beat.vld && beat.slot_valid &&
                    (!victim_found_reg ||
                     (beat.entry.use_count < victim_cnt_reg) ||
                     ((beat.entry.use_count == victim_cnt_reg) &&
                      (beat.entry.last_touch < victim_touch_reg)));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_found_reg  <= 1'b0;
            victim_found_reg <= 1'b0;
            free_found_reg   <= 1'b0;
        end else if (clear) begin
            match_found_reg  <= 1'b0;
            victim_found_reg <= 1'b0;
            free_found_reg   <= 1'b0;
        end else begin
            if (is_match) begin
                match_found_reg <= 1'b1;
            end
            if (is_better) begin
                victim_found_reg <= 1'b1;
            end
            if (is_free) begin
                free_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (is_match) begin
            match_idx_reg   <= beat.idx;
            match_entry_reg <= beat.entry;
        end
        if (is_better) begin
            victim_idx_reg   <= beat.idx;
            victim_cnt_reg   <= beat.entry.use_count;
            victim_touch_reg <= beat.entry.last_touch;
        end
        if (is_free) begin
            free_idx_reg <= beat.idx;
        end
    end

    always_comb begin
        result.match_found  = match_found_reg;
        result.match_idx    = match_idx_reg;
        result.match_entry  = match_entry_reg;
        result.victim_found = victim_found_reg;
        result.victim_idx   = victim_idx_reg;
        result.free_found   = free_found_reg;
        result.free_idx     = free_idx_reg;
    end

endmodule

// ===== rtl/core/lfu_cache_table_unit.sv =====
// Top level of the LFU cache table: controller, valid bits, slot memory, result register.
// Depends on lfu_pkg, lfu_slot_ram and lfu_scan.
//
// Key-value cache with least-frequently-used replacement and oldest-touch tie-break.
// Every operation reads all ENTRIES slots from the slot memory, one per cycle through
// its single read port, then drains the read pipeline and, once the output register is
// free, writes the touched or inserted slot, if there is one. No new input is accepted
// until the operation is done, and the result is loaded into the output register in the
// update step. A finished result waits in that register, so the next operation may start
// while it is still pending. The capacity register may be written whenever the block
// is idle.
module lfu_cache_table_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [lfu_pkg::CAP_W-1:0]        cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_func,
    input  logic signed [lfu_pkg::KEY_W-1:0] s_lookup_key,
    input  logic signed [lfu_pkg::VAL_W-1:0] s_store_value,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_hit,
    output logic signed [lfu_pkg::VAL_W-1:0] m_read_value
);
    import lfu_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic [CAP_W-1:0]   capacity_limit_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [OCC_W-1:0]   occ_reg;
    logic [TOUCH_W-1:0] touch_clock_reg;
    logic [IDX_W-1:0]   rd_idx_reg;

    func_t              func_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VAL_W-1:0]   value_reg;

    logic               beat_vld_reg;
    logic [IDX_W-1:0]   beat_idx_reg;
    logic               beat_slot_valid_reg;
    scan_beat_t         beat_in;
    scan_result_t       scan_res;
    slot_entry_t        rd_entry;
    logic [ENTRY_W-1:0] rd_data;

    logic               m_valid_reg;
    logic               m_hit_reg;
    logic [VAL_W-1:0]   m_read_value_reg;

    logic               accept;
    logic               out_free;
    logic               do_update;
    logic               scan_last;
    logic [CMP_W-1:0]   cap_eff;
    logic               evict;
    logic               insert;
    logic [IDX_W-1:0]   ins_idx;
    logic [TOUCH_W-1:0] touch_inc;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    slot_entry_t        wr_entry;

    // Control: next state, handshake and update decisions.
    always_comb begin
        state_next = state_reg;
        s_ready    = (state_reg == ST_IDLE);
        accept     = s_valid && s_ready;
        out_free   = !m_valid_reg || m_ready;
        do_update  = 1'b0;
        scan_last  = (rd_idx_reg == IDX_W'(ENTRIES - 1));
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (out_free) begin
                    do_update  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Update datapath: hit touches the matched slot, a new key may evict and insert.
    always_comb begin
        cap_eff   = (CMP_W'(capacity_limit_reg) > CMP_W'(ENTRIES)) ?
                    CMP_W'(ENTRIES) : CMP_W'(capacity_limit_reg);
        touch_inc = touch_clock_reg + TOUCH_W'(1);
        insert    = !scan_res.match_found && (func_reg == FUNC_PUT) && (cap_eff != '0);
        evict     = insert && (CMP_W'(occ_reg) >= cap_eff);
        if (evict && !(scan_res.free_found && (scan_res.free_idx < scan_res.victim_idx))) begin
            ins_idx = scan_res.victim_idx;
        end else begin
            ins_idx = scan_res.free_idx;
        end

        wr_en    = do_update && (scan_res.match_found || insert);
        wr_addr  = scan_res.match_found ? scan_res.match_idx : ins_idx;
        wr_entry = scan_res.match_entry;
        wr_entry.last_touch = touch_inc;
        if (scan_res.match_found) begin
            if (scan_res.match_entry.use_count != '1) begin
                wr_entry.use_count = scan_res.match_entry.use_count + CNT_W'(1);
            end
            if (func_reg == FUNC_PUT) begin
                wr_entry.value = value_reg;
            end
        end else begin
            wr_entry.key       = key_reg;
            wr_entry.value     = value_reg;
            wr_entry.use_count = CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_limit_reg <= CAP_RESET;
            valid_reg          <= '0;
            occ_reg            <= '0;
            touch_clock_reg    <= '0;
            rd_idx_reg         <= '0;
            beat_vld_reg       <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                capacity_limit_reg <= cfg_wr_data;
            end
            if (accept) begin
                rd_idx_reg <= '0;
            end else if (state_reg == ST_SCAN) begin
                rd_idx_reg <= rd_idx_reg + IDX_W'(1);
            end
            beat_vld_reg <= (state_reg == ST_SCAN);
            if (wr_en) begin
                touch_clock_reg <= touch_inc;
            end
            if (do_update && insert) begin
                // Clear the victim first so that reusing its slot leaves it valid.
                if (evict) begin
                    valid_reg[scan_res.victim_idx] <= 1'b0;
                end
                valid_reg[ins_idx] <= 1'b1;
                if (!evict) begin
                    occ_reg <= occ_reg + OCC_W'(1);
                end
            end
            if (do_update) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg  <= func_t'(s_func);
            key_reg   <= s_lookup_key;
            value_reg <= s_store_value;
        end
        beat_idx_reg        <= rd_idx_reg;
        beat_slot_valid_reg <= valid_reg[rd_idx_reg];
        if (do_update) begin
            m_hit_reg <= scan_res.match_found;
            if (scan_res.match_found && (func_reg == FUNC_GET)) begin
                m_read_value_reg <= scan_res.match_entry.value;
            end else begin
                m_read_value_reg <= '0;
            end
        end
    end

    lfu_slot_ram #(
        .DATA_W (ENTRY_W),
        .DEPTH  (ENTRIES),
        .ADDR_W (IDX_W)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (state_reg == ST_SCAN),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_data)
    );

    assign rd_entry = slot_entry_t'(rd_data);

    always_comb begin
        beat_in.vld        = beat_vld_reg;
        beat_in.idx        = beat_idx_reg;
        beat_in.slot_valid = beat_slot_valid_reg;
        beat_in.entry      = rd_entry;
    end

    lfu_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (accept),
        .key     (key_reg),
        .beat    (beat_in),
        .result  (scan_res)
    );

    assign m_valid      = m_valid_reg;
    assign m_hit        = m_hit_reg;
    assign m_read_value = m_read_value_reg;

`ifndef SYNTHESIS
    a_occ_matches_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_reg) == 32'(occ_reg))
        else $error("occupancy does not match the number of valid slots");

    a_evict_has_victim: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_update && evict) |-> scan_res.victim_found)
        else $error("eviction without a victim");

    a_insert_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_update && insert && !evict) |-> scan_res.free_found)
        else $error("insert without a free slot");

    a_result_after_update: assert property (@(posedge aclk) disable iff (!aresetn)
        do_update |=> (m_valid && (state_reg == ST_IDLE)))
        else $error("result transfer not offered after update");
`endif

endmodule
